@@ design/cct_pkg.sv @@
// shared types, constants and the arctangent table of the cone checker texture unit
`default_nettype none
package cct_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int DIV_BITS   = 42;
  localparam int CORDIC_STEPS = 31;
  localparam int NUM_CELLS  = DIV_BITS;
  localparam int IDX_W      = $clog2(NUM_CELLS);

  typedef enum logic [2:0] {
    REG_ANGULAR_CELLS = 3'd0,
    REG_HEIGHT_CELLS  = 3'd1,
    REG_HEIGHT_SPAN   = 3'd2,
    REG_RING_WIDTH    = 3'd3,
    REG_SPOKE_WIDTH   = 3'd4,
    REG_EVEN_COLOR    = 3'd5,
    REG_ODD_COLOR     = 3'd6,
    REG_OUTLINE_COLOR = 3'd7
  } cct_reg_t;

  typedef struct packed {
    logic [10:0] angular_cells;
    logic [10:0] height_cells;
    logic [30:0] height_span;
    logic [16:0] ring_line_width;
    logic [16:0] spoke_line_width;
    logic [23:0] even_color;
    logic [23:0] odd_color;
    logic [23:0] outline_color;
  } cct_cfg_t;

  typedef struct packed {
    logic               valid;
    logic               zero;
    logic signed [63:0] c;
    logic signed [63:0] s;
    logic [31:0]        acc;
    logic [DIV_BITS-1:0] dvd;
    logic [30:0]        rem;
    logic               qlsb;
    logic               neg;
  } cct_stage_t;

  // angle of atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] turn_angle(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ design/cct_if.sv @@
// channel interfaces: hit points in, texels out, register writes
`default_nettype none
interface hit_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] hit_x;
  logic signed [31:0] hit_y;
  logic signed [31:0] hit_z;
  modport source (output valid, hit_x, hit_y, hit_z, input ready);
  modport sink   (input valid, hit_x, hit_y, hit_z, output ready);
endinterface

interface texel_if;
  logic        valid;
  logic        ready;
  logic [23:0] texel_color;
  logic        on_line;
  modport source (output valid, texel_color, on_line, input ready);
  modport sink   (input valid, texel_color, on_line, output ready);
endinterface

interface cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [30:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/cct_cell.sv @@
// one cell of the chain: a cordic vectoring step (only where idx is below CORDIC_STEPS) and a restoring division step
`default_nettype none
module cct_cell (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic [cct_pkg::IDX_W-1:0] idx,
  input  wire logic [30:0]             hh,
  input  wire cct_pkg::cct_stage_t     d,
  output cct_pkg::cct_stage_t          q
);

  cct_pkg::cct_stage_t q_next;
  logic [4:0]          sh;
  logic signed [63:0]  dc;
  logic signed [63:0]  ds;
  logic [31:0]         ang;
  logic [31:0]         part;
  logic [32:0]         diff;
  logic                ge;

  always_comb begin
    sh   = idx[4:0];
    dc   = d.c >>> sh;
    ds   = d.s >>> sh;
    ang  = cct_pkg::turn_angle(sh);
    part = {d.rem, d.dvd[cct_pkg::DIV_BITS-1]};
    diff = {1'b0, part} - {2'b00, hh};
    ge   = ~diff[32];
    q_next = d;
    if (idx < cct_pkg::IDX_W'(cct_pkg::CORDIC_STEPS)) begin
      if (d.s > 0) begin
        q_next.c   = d.c + ds;
        q_next.s   = d.s - dc;
        q_next.acc = d.acc + ang;
      end else begin
        q_next.c   = d.c - ds;
        q_next.s   = d.s + dc;
        q_next.acc = d.acc - ang;
      end
    end
    q_next.rem  = ge ? diff[30:0] : part[30:0];
    q_next.dvd  = {d.dvd[cct_pkg::DIV_BITS-2:0], 1'b0};
    q_next.qlsb = ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule
`default_nettype wire

@@ design/cct_shade.sv @@
// cell indices, border line tests and colour choice, ending in the output register
`default_nettype none
module cct_shade (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire cct_pkg::cct_cfg_t   cfg,
  input  wire logic [30:0]         hh,
  input  wire cct_pkg::cct_stage_t d,
  output logic                     valid,
  output logic [23:0]              color,
  output logic                     line
);

  localparam int AB = cct_pkg::ANGLE_BITS;
  localparam int SW = AB + 18;

  logic [10:0]   na;
  logic [31:0]   acc;
  logic [31:0]   acc_rnd;
  logic [AB-1:0] phi;
  logic [30:0]   r_fix;

  // first stage registers
  logic          p1_valid;
  logic [AB:0]   p1_t;
  logic          p1_qpar;
  logic [30:0]   p1_r;
  logic [47:0]   p1_rwh;

  logic [SW-1:0] fa_s;
  logic [SW-1:0] sw_s;
  logic [48:0]   r_s;
  logic [48:0]   rwh_s;
  logic [48:0]   h_s;
  logic          spoke;
  logic          ring;
  logic          par;
  logic          line_next;
  logic [23:0]   color_next;

  always_comb begin
    na      = (cfg.angular_cells == 11'd0) ? 11'd1 : cfg.angular_cells;
    acc     = d.zero ? 32'd0 : d.acc;
    acc_rnd = acc + (32'd1 << (31 - AB));
    phi     = acc_rnd[31:32-AB];
    // floor division of a negative dividend was done on its complement
    r_fix   = d.neg ? (hh - 31'd1 - d.rem) : d.rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_t    <= (AB+1)'((AB+11)'(phi) * (AB+11)'(na));
      p1_qpar <= d.qlsb ^ d.neg;
      p1_r    <= r_fix;
      p1_rwh  <= 48'(cfg.ring_line_width) * 48'(hh);
    end
  end

  always_comb begin
    fa_s  = SW'(p1_t[AB-1:0]) << 17;
    sw_s  = SW'(cfg.spoke_line_width) << AB;
    spoke = (fa_s < sw_s) || ((fa_s + sw_s) > (SW'(1) << (17 + AB)));
    r_s   = 49'(p1_r) << 17;
    rwh_s = 49'(p1_rwh);
    h_s   = 49'(hh) << 17;
    ring  = (r_s < rwh_s) || ((r_s + rwh_s) > h_s);
    par   = p1_t[AB] ^ p1_qpar;
    line_next = spoke || ring;
    if (line_next) begin
      color_next = cfg.outline_color;
    end else if (par) begin
      color_next = cfg.odd_color;
    end else begin
      color_next = cfg.even_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      color <= color_next;
      line  <= line_next;
    end
  end

endmodule
`default_nettype wire

@@ design/cone_checker_texture_unit.sv @@
// top level of the cone checker texture unit
// Takes one hit point per cycle unless stalled, giving one texel per hit point in order
// through an input register, a chain of 42 cells (the first 31 also run the cordic steps
// of the azimuth, all of them run one bit of the height division) and two shading
// stages, the last of which is the output register. The whole chain advances together
// and holds only while a finished texel waits to be taken. Register writes are taken
// in every cycle and must only happen while no hit point is in flight.
`default_nettype none
module cone_checker_texture_unit (
  input  wire logic clk,
  input  wire logic rst,
  hit_if.sink       hit,
  texel_if.source   texel,
  cfg_if.sink       cfg
);

  cct_pkg::cct_cfg_t   regs;
  cct_pkg::cct_stage_t chain [0:cct_pkg::NUM_CELLS];
  cct_pkg::cct_stage_t s0_next;
  logic                en;
  logic [30:0]         hh;
  logic [10:0]         nh;
  logic signed [63:0]  xw;
  logic signed [63:0]  zw;
  logic signed [63:0]  cw;
  logic signed [63:0]  sw;
  logic signed [43:0]  qy;

  assign en        = ~(texel.valid & ~texel.ready);
  assign hit.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.angular_cells    <= 11'd20;
      regs.height_cells     <= 11'd10;
      regs.height_span      <= 31'd131072;
      regs.ring_line_width  <= 17'd0;
      regs.spoke_line_width <= 17'd0;
      regs.even_color       <= 24'hFFFFFF;
      regs.odd_color        <= 24'h808080;
      regs.outline_color    <= 24'h000000;
    end else if (cfg.valid) begin
      case (cct_pkg::cct_reg_t'(cfg.index))
        cct_pkg::REG_ANGULAR_CELLS: regs.angular_cells    <= cfg.data[10:0];
        cct_pkg::REG_HEIGHT_CELLS:  regs.height_cells     <= cfg.data[10:0];
        cct_pkg::REG_HEIGHT_SPAN:   regs.height_span      <= cfg.data[30:0];
        cct_pkg::REG_RING_WIDTH:    regs.ring_line_width  <= cfg.data[16:0];
        cct_pkg::REG_SPOKE_WIDTH:   regs.spoke_line_width <= cfg.data[16:0];
        cct_pkg::REG_EVEN_COLOR:    regs.even_color       <= cfg.data[23:0];
        cct_pkg::REG_ODD_COLOR:     regs.odd_color        <= cfg.data[23:0];
        cct_pkg::REG_OUTLINE_COLOR: regs.outline_color    <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hh = (regs.height_span == 31'd0) ? 31'd1 : regs.height_span;
    nh = (regs.height_cells == 11'd0) ? 11'd1 : regs.height_cells;
    xw = 64'(hit.hit_x);
    zw = 64'(hit.hit_z);
    // turn into the right half plane, then scale by 2^28
    cw = (zw < 0) ? -zw : zw;
    sw = (zw < 0) ? -xw : xw;
    qy = 44'(hit.hit_y) * $signed({33'd0, nh});
    s0_next.valid = hit.valid;
    s0_next.zero  = (hit.hit_x == 32'sd0) && (hit.hit_z == 32'sd0);
    s0_next.c     = cw <<< 28;
    s0_next.s     = sw <<< 28;
    s0_next.acc   = (zw < 0) ? 32'h80000000 : 32'h00000000;
    s0_next.neg   = qy[43];
    s0_next.dvd   = qy[43] ? ~qy[cct_pkg::DIV_BITS-1:0] : qy[cct_pkg::DIV_BITS-1:0];
    s0_next.rem   = 31'd0;
    s0_next.qlsb  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0] <= s0_next;
    end
  end

  for (genvar k = 0; k < cct_pkg::NUM_CELLS; k++) begin : g_cell
    cct_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .idx (cct_pkg::IDX_W'(k)),
      .hh  (hh),
      .d   (chain[k]),
      .q   (chain[k+1])
    );
  end

  cct_shade u_shade (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .cfg   (regs),
    .hh    (hh),
    .d     (chain[cct_pkg::NUM_CELLS]),
    .valid (texel.valid),
    .color (texel.texel_color),
    .line  (texel.on_line)
  );

endmodule
`default_nettype wire

@@ design/cct_check.sv @@
// port level assertions for the cone checker texture unit and their binding
`default_nettype none
module cct_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [23:0] out_color,
  input wire logic        out_line,
  input wire logic        cfg_ready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_color) && $stable(out_line))
    else $error("stalled texel changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == !(out_valid && !out_ready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("texel valid right after reset");

  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("register port not ready");

  a_idle: assert property (@(posedge clk) disable iff (rst)
    !in_valid && !out_valid |-> in_ready)
    else $error("idle block not ready");

endmodule

bind cone_checker_texture_unit cct_check u_cct_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (hit.valid),
  .in_ready  (hit.ready),
  .out_valid (texel.valid),
  .out_ready (texel.ready),
  .out_color (texel.texel_color),
  .out_line  (texel.on_line),
  .cfg_ready (cfg.ready)
);
`default_nettype wire
